// ----- hdl/hsqrt_pkg.sv -----
// ----------------------------------------------------------------------------
// hsqrt_pkg
// Shared widths, microcode formats and the control program of the
// fixed-point Heron square root sequencer.
// ----------------------------------------------------------------------------
package hsqrt_pkg;

    // Field widths and fixed-point format
    localparam int DATA_W             = 32;
    localparam int ROOT_W             = 24;
    localparam int FRACTION_BITS      = 16;
    localparam int DEF_MAX_ITERATIONS = 8;
    localparam logic [DATA_W-1:0] TOL_RESET = 32'd66;

    // Integer start search: largest m with m*m*2^F below the radicand
    localparam int SEARCH_BITS = (DATA_W - FRACTION_BITS + 1) / 2;
    localparam int SRCH_W      = 2 * SEARCH_BITS + FRACTION_BITS;

    // Quotient of (a << F) / x, one bit per step
    localparam int DIV_W = DATA_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // Microcode word
    localparam int PC_W = 4;
    typedef logic [3:0]      t_op;
    typedef logic [2:0]      t_cond;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Datapath operations
    localparam t_op OP_NOP      = 4'd0;
    localparam t_op OP_LOAD     = 4'd1;
    localparam t_op OP_SRCH     = 4'd2;
    localparam t_op OP_GUESS    = 4'd3;
    localparam t_op OP_SQUARE   = 4'd4;
    localparam t_op OP_DIV_INIT = 4'd5;
    localparam t_op OP_DIV_STEP = 4'd6;
    localparam t_op OP_UPDATE   = 4'd7;
    localparam t_op OP_OUT_PASS = 4'd8;
    localparam t_op OP_OUT_FAIL = 4'd9;

    // Jump conditions
    localparam t_cond C_NEXT     = 3'd0;
    localparam t_cond C_ALWAYS   = 3'd1;
    localparam t_cond C_IDLE     = 3'd2;
    localparam t_cond C_AZERO    = 3'd3;
    localparam t_cond C_CNT_MORE = 3'd4;
    localparam t_cond C_WITHIN   = 3'd5;
    localparam t_cond C_ITER_END = 3'd6;

    // Program addresses
    localparam t_pc PC_IDLE     = 4'd0;
    localparam t_pc PC_CHECK    = 4'd1;
    localparam t_pc PC_SRCH     = 4'd2;
    localparam t_pc PC_GUESS    = 4'd3;
    localparam t_pc PC_SQUARE   = 4'd4;
    localparam t_pc PC_TEST     = 4'd5;
    localparam t_pc PC_LIMIT    = 4'd6;
    localparam t_pc PC_DIV_INIT = 4'd7;
    localparam t_pc PC_DIV      = 4'd8;
    localparam t_pc PC_UPDATE   = 4'd9;
    localparam t_pc PC_PASS     = 4'd10;
    localparam t_pc PC_FAIL     = 4'd11;

    // Control program ROM
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:     w = '{OP_LOAD,     C_IDLE,     PC_IDLE};
            PC_CHECK:    w = '{OP_NOP,      C_AZERO,    PC_PASS};
            PC_SRCH:     w = '{OP_SRCH,     C_CNT_MORE, PC_SRCH};
            PC_GUESS:    w = '{OP_GUESS,    C_NEXT,     PC_IDLE};
            PC_SQUARE:   w = '{OP_SQUARE,   C_NEXT,     PC_IDLE};
            PC_TEST:     w = '{OP_NOP,      C_WITHIN,   PC_PASS};
            PC_LIMIT:    w = '{OP_NOP,      C_ITER_END, PC_FAIL};
            PC_DIV_INIT: w = '{OP_DIV_INIT, C_NEXT,     PC_IDLE};
            PC_DIV:      w = '{OP_DIV_STEP, C_CNT_MORE, PC_DIV};
            PC_UPDATE:   w = '{OP_UPDATE,   C_ALWAYS,   PC_SQUARE};
            PC_PASS:     w = '{OP_OUT_PASS, C_ALWAYS,   PC_IDLE};
            PC_FAIL:     w = '{OP_OUT_FAIL, C_ALWAYS,   PC_IDLE};
            default:     w = '{OP_NOP,      C_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/heron_square_root_fixed.sv -----
// ----------------------------------------------------------------------------
// heron_square_root_fixed
// Q16.16 square root by Heron iteration, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// A run ends when the tolerance is met, when the limit of MAX_ITERATIONS Heron
// updates is reached, or straight after the check for a zero radicand. An update
// is a 48-step division plus 5 control steps.
// Throughput: one item at a time; start is taken again in the cycle o_done pulses.
// Synchronous active-low reset idles the sequencer and sets tolerance to 66;
// results cannot be stalled by the receiver.
module heron_square_root_fixed
    import hsqrt_pkg::*;
#(
    parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DATA_W-1:0] i_radicand,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [DATA_W-1:0] i_cfg_data,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_converged
);

    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS);

    // Sequencer and datapath registers
    t_pc                      r_pc;
    t_pc                      n_pc;
    logic                     r_done;
    logic                     n_done;
    logic [DATA_W-1:0]        r_tol;
    logic [DATA_W-1:0]        r_a;
    logic [DATA_W-1:0]        r_x;
    logic [2*DATA_W-1:0]      r_sq;
    logic [DATA_W-1:0]        r_rem;
    logic [DIV_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic [SEARCH_BITS-1:0]   r_m;
    logic [SEARCH_BITS-1:0]   r_bit;
    logic [ITER_W-1:0]        r_iter;
    logic [ROOT_W-1:0]        r_root;
    logic                     r_conv;

    t_uword                   uw;
    logic                     take;

    // Start search
    logic [SEARCH_BITS-1:0]   trial;
    logic [2*SEARCH_BITS-1:0] trial_sq;
    logic [SRCH_W-1:0]        srch_lhs;
    logic                     srch_below;
    logic [SEARCH_BITS-1:0]   guess_m;
    logic [DATA_W-1:0]        guess_x;

    // Tolerance test
    logic [2*DATA_W-1:0]      sq_full;
    logic [2*DATA_W-1:0]      tst_lhs;
    logic [2*DATA_W-1:0]      tst_diff;
    logic [2*DATA_W-1:0]      tol_sh;
    logic                     tol_met;

    // Division step and update
    logic [DATA_W:0]          div_sh;
    logic [DATA_W:0]          div_dif;
    logic                     div_ge;
    logic [DIV_W:0]           upd_sum;
    logic [DIV_W-1:0]         upd_half;
    logic                     upd_sat;
    logic                     root_sat;
    logic [ROOT_W-1:0]        root_val;

    assign uw = ucode(r_pc);

    // Start search: greedy bit test of m*m*2^F < a
    assign trial      = r_m | r_bit;
    assign trial_sq   = {{SEARCH_BITS{1'b0}}, trial} * {{SEARCH_BITS{1'b0}}, trial};
    assign srch_lhs   = {trial_sq, {FRACTION_BITS{1'b0}}};
    assign srch_below = srch_lhs < SRCH_W'(r_a);
    assign guess_m    = (r_m == '0) ? SEARCH_BITS'(1) : r_m;
    assign guess_x    = DATA_W'({guess_m, {FRACTION_BITS{1'b0}}});

    // Tolerance test: |(a << F) - x*x| <= (tol << F)
    assign sq_full  = r_x * r_x;
    assign tst_lhs  = (2*DATA_W)'({r_a, {FRACTION_BITS{1'b0}}});
    assign tol_sh   = (2*DATA_W)'({r_tol, {FRACTION_BITS{1'b0}}});
    assign tst_diff = (r_sq >= tst_lhs) ? (r_sq - tst_lhs) : (tst_lhs - r_sq);
    assign tol_met  = tst_diff <= tol_sh;

    // Restoring division, one quotient bit per step
    assign div_sh  = {r_rem, r_quo[DIV_W-1]};
    assign div_dif = div_sh - {1'b0, r_x};
    assign div_ge  = div_sh >= {1'b0, r_x};

    // Average of x and quotient, saturated to the working register
    assign upd_sum  = (DIV_W+1)'(r_x) + {1'b0, r_quo};
    assign upd_half = upd_sum[DIV_W:1];
    assign upd_sat  = |upd_half[DIV_W-1:DATA_W];

    // Root clipped to the output format
    assign root_sat = |r_x[DATA_W-1:ROOT_W];
    assign root_val = root_sat ? {ROOT_W{1'b1}} : r_x[ROOT_W-1:0];

    // Jump condition select
    always_comb begin
        unique case (uw.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_IDLE:     take = !start;
            C_AZERO:    take = (r_a == '0);
            C_CNT_MORE: take = (r_cnt != CNT_W'(1));
            C_WITHIN:   take = tol_met;
            C_ITER_END: take = (r_iter == ITER_LAST);
            default:    take = 1'b0;
        endcase
        n_pc   = take ? uw.target : t_pc'(r_pc + 1'b1);
        n_done = (uw.op == OP_OUT_PASS) || (uw.op == OP_OUT_FAIL);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_IDLE;
            r_done <= 1'b0;
            r_tol  <= TOL_RESET;
        end else begin
            r_pc   <= n_pc;
            r_done <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    // Datapath, driven by the current control word
    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            OP_LOAD: begin
                if (start) begin
                    r_a    <= i_radicand;
                    r_x    <= '0;
                    r_m    <= '0;
                    r_bit  <= {1'b1, {(SEARCH_BITS-1){1'b0}}};
                    r_cnt  <= CNT_W'(SEARCH_BITS);
                    r_iter <= '0;
                end
            end
            OP_SRCH: begin
                if (srch_below) begin
                    r_m <= trial;
                end
                r_bit <= r_bit >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_GUESS: begin
                r_x <= guess_x;
            end
            OP_SQUARE: begin
                r_sq <= sq_full;
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_quo <= {r_a, {FRACTION_BITS{1'b0}}};
                r_cnt <= CNT_W'(DIV_W);
                if (r_x == '0) begin
                    r_x <= DATA_W'(1);
                end
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? div_dif[DATA_W-1:0] : div_sh[DATA_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            OP_UPDATE: begin
                r_x    <= upd_sat ? {DATA_W{1'b1}} : upd_half[DATA_W-1:0];
                r_iter <= r_iter + 1'b1;
            end
            OP_OUT_PASS: begin
                r_root <= root_val;
                r_conv <= 1'b1;
            end
            OP_OUT_FAIL: begin
                r_root <= root_val;
                r_conv <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign busy        = (r_pc != PC_IDLE);
    assign o_cfg_ready = (r_pc == PC_IDLE);
    assign o_done      = r_done;
    assign o_root      = r_root;
    assign o_converged = r_conv;

    // Checks
    a_done_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_pc) == PC_PASS || $past(r_pc) == PC_FAIL))
        else $error("result strobe without an output step");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_fail_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_converged) |-> (r_iter == ITER_LAST))
        else $error("not converged before iteration limit");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_DIV) |-> (r_x != '0))
        else $error("division by zero root");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_FAIL)
        else $error("program counter out of range");

endmodule

// ----- test/tb_heron_square_root_fixed.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heron_square_root_fixed
// Drives Q16.16 radicands into the Heron square root and checks every root
// and converged flag against a bit-exact predictor kept in the bench. The
// tolerance register is rewritten between phases while the block is idle,
// and the sender idles at random except during one back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_heron_square_root_fixed
    import hsqrt_pkg::*;
();

    localparam logic [63:0] ROOT_MAX = 64'h0000_0000_00FF_FFFF;
    localparam logic [63:0] X_MAX    = 64'h0000_0000_FFFF_FFFF;
    localparam int          DRAIN_CYCLES = 450;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              converged;
    } t_root_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [DATA_W-1:0] i_radicand;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [DATA_W-1:0] i_cfg_data;
    logic              o_done;
    logic [ROOT_W-1:0] o_root;
    logic              o_converged;

    t_root_result      expected_roots[$];
    t_root_result      oldest_root;
    logic [DATA_W-1:0] tolerance_model;
    bit                idle_enable;
    int                mismatch_count;

    heron_square_root_fixed dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_radicand  (i_radicand),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_root      (o_root),
        .o_converged (o_converged)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] %s", $time, what);
    endtask

    // Bit-exact root prediction: integer start search, then Heron updates
    function automatic t_root_result predict_root(input logic [DATA_W-1:0] radicand,
                                                  input logic [DATA_W-1:0] tol);
        logic [63:0]  a;
        logic [63:0]  m;
        logic [63:0]  x;
        logic [63:0]  q;
        logic [63:0]  scaled;
        logic [63:0]  tol_scaled;
        logic [63:0]  sq;
        logic [63:0]  diff;
        t_root_result res;
        a = {32'd0, radicand};
        res.converged = 1'b0;
        if (a == 64'd0) begin
            res.root      = '0;
            res.converged = 1'b1;
            return res;
        end
        // smallest m with m*m >= a, minus one; never below 1.0
        m = 64'd0;
        while (((m * m) << FRACTION_BITS) < a) m++;
        if (m < 64'd2) m = 64'd2;
        x          = (m - 64'd1) << FRACTION_BITS;
        scaled     = a << FRACTION_BITS;
        tol_scaled = {32'd0, tol} << FRACTION_BITS;
        for (int step = 0; step <= DEF_MAX_ITERATIONS; step++) begin
            sq   = x * x;
            diff = (scaled >= sq) ? (scaled - sq) : (sq - scaled);
            if (diff <= tol_scaled) begin
                res.converged = 1'b1;
                break;
            end
            if (step == DEF_MAX_ITERATIONS) break;
            if (x == 64'd0) x = 64'd1;
            q = scaled / x;
            x = (x + q) >> 1;
            if (x > X_MAX) x = X_MAX;
        end
        res.root = (x > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0] : x[ROOT_W-1:0];
        return res;
    endfunction

    // Random radicand with weight on squares, small values and the top end
    function automatic logic [DATA_W-1:0] random_radicand();
        logic [63:0] r;
        logic [63:0] mask;
        int          kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: r = {32'd0, $urandom};
            3:       r = $urandom_range(1, 32'h0000_FFFF);
            4:       r = $urandom_range(1, 255);
            5: begin
                r = $urandom_range(0, 32'h00FF_FFFF);
                r = (r * r) >> FRACTION_BITS;
            end
            6: begin
                r = $urandom_range(1, 255);
                r = ((r * r) << FRACTION_BITS) + $urandom_range(0, 64) - 32;
            end
            7: begin
                mask = (64'd1 << $urandom_range(1, 32)) - 64'd1;
                r    = {32'd0, $urandom} & mask;
            end
            8:       r = 64'h0000_0000_FFFF_FFFF - $urandom_range(0, 1000);
            default: r = 64'd1 << $urandom_range(0, 31);
        endcase
        return r[DATA_W-1:0];
    endfunction

    // Send one radicand; returns at the edge that accepts the transaction
    task automatic send_radicand(input logic [DATA_W-1:0] value);
        int gap;
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 99) < 31) begin
            start = 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 500)
                                              : $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        start      = 1'b1;
        i_radicand = value;
        do @(posedge i_clk); while (busy);
        expected_roots.push_back(predict_root(value, tolerance_model));
    endtask

    // Stop sending and wait until every result is back
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_roots.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Tolerance write, only once the block has gone idle
    task automatic write_tolerance(input logic [DATA_W-1:0] value);
        wait_idle();
        if (idle_enable && $urandom_range(0, 99) < 31)
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tolerance_model = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_radicand(random_radicand());
    endtask

    // Corner radicands under the reset tolerance
    task automatic test_reset_tolerance();
        send_radicand(32'h0000_0000);    // zero radicand
        send_radicand(32'h0000_0001);
        send_radicand(32'h0000_0002);
        send_radicand(32'h0000_0003);
        send_radicand(32'h0000_8000);    // 0.5, start guess clamped to one
        send_radicand(32'h0000_FFFF);
        send_radicand(32'h0001_0000);    // 1.0
        send_radicand(32'h0001_0001);
        send_radicand(32'h0002_0000);
        send_radicand(32'h0004_0000);    // exact square
        send_radicand(32'h0064_0000);
        send_radicand(32'h8000_0000);
        send_radicand(32'hFFFF_0000);
        send_radicand(32'hFFFF_FFFF);    // widest root
    endtask

    // Zero tolerance: most items run out of iterations
    task automatic test_exact_tolerance();
        write_tolerance(32'h0000_0000);
        send_radicand(32'h0000_0001);
        send_radicand(32'h0002_0000);
        send_radicand(32'h0009_0000);
        send_radicand(32'h1234_5678);
        send_radicand(32'hFFFF_FFFF);
        send_random(250);
    endtask

    // Widest tolerance: the start guess is always accepted
    task automatic test_loose_tolerance();
        write_tolerance(32'hFFFF_FFFF);
        send_radicand(32'h0000_0000);
        send_radicand(32'h0000_0001);
        send_radicand(32'h0000_8000);
        send_radicand(32'hFFFF_FFFF);
        send_random(100);
    endtask

    // Several random tolerances of assorted magnitudes
    task automatic test_random_tolerances();
        repeat (4) begin
            write_tolerance($urandom >> $urandom_range(0, 31));
            send_random(150);
        end
    endtask

    // Default tolerance rewritten, sender never idles
    task automatic test_back_to_back();
        write_tolerance(TOL_RESET);
        idle_enable = 1'b0;
        send_random(200);
        idle_enable = 1'b1;
    endtask

    // Result checker: each strobe is one transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected result root=%h converged=%b",
                                          o_root, o_converged));
            end else begin
                oldest_root = expected_roots.pop_front();
                if (o_root !== oldest_root.root)
                    report_mismatch($sformatf("root %h, expected %h",
                                              o_root, oldest_root.root));
                if (o_converged !== oldest_root.converged)
                    report_mismatch($sformatf("converged %b, expected %b",
                                              o_converged, oldest_root.converged));
            end
        end
    end

    // Main sequence
    initial begin
        int drain;
        start           = 1'b0;
        i_radicand      = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        idle_enable     = 1'b1;
        mismatch_count  = 0;
        tolerance_model = TOL_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_tolerance();
        test_exact_tolerance();
        test_loose_tolerance();
        test_random_tolerances();
        test_back_to_back();

        // Drain outstanding results, then allow one full worst-case latency
        @(negedge i_clk);
        start = 1'b0;
        drain = 0;
        while (expected_roots.size() != 0 && drain < 4 * DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_roots.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_roots.size()));
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/hsqrt_pkg.sv
hdl/heron_square_root_fixed.sv
test/tb_heron_square_root_fixed.sv
